@@ hw/rtl/mme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg: shared types and microcode for the modular exponentiation core
// Control word layout, sequencer status, register indexes and the program.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int unsigned PC_W      = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd1;

  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_LOAD    = 4'd1,
    ACT_RED_GO  = 4'd2,
    ACT_MACC_GO = 4'd3,
    ACT_MSQ_GO  = 4'd4,
    ACT_WR_SQ   = 4'd5,
    ACT_WR_ACC  = 4'd6,
    ACT_SHIFT   = 4'd7,
    ACT_EMIT    = 4'd8
  } act_e;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_JUMP     = 3'd1,
    C_IN       = 3'd2,
    C_UNIT     = 3'd3,
    C_OUT      = 3'd4,
    C_EZERO    = 3'd5,
    C_EBIT_CLR = 3'd6
  } cond_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_fire;
    logic unit_done;
    logic out_free;
    logic e_zero;
    logic e_bit0;
  } seq_stat_t;

  typedef struct packed {
    act_e act;
    logic fire;
  } seq_ctrl_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_BIT   = 4'd4;
  localparam logic [PC_W-1:0] PC_SHIFT = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd11;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{act: ACT_NONE, cond: C_JUMP, target: PC_IDLE};
    case (pc)
      4'd0:    w = '{act: ACT_LOAD,    cond: C_IN,       target: PC_IDLE};
      4'd1:    w = '{act: ACT_NONE,    cond: C_EZERO,    target: PC_EMIT};
      4'd2:    w = '{act: ACT_RED_GO,  cond: C_NEXT,     target: PC_IDLE};
      4'd3:    w = '{act: ACT_WR_SQ,   cond: C_UNIT,     target: PC_BIT};
      4'd4:    w = '{act: ACT_NONE,    cond: C_EBIT_CLR, target: PC_SHIFT};
      4'd5:    w = '{act: ACT_MACC_GO, cond: C_NEXT,     target: PC_IDLE};
      4'd6:    w = '{act: ACT_WR_ACC,  cond: C_UNIT,     target: PC_SHIFT};
      4'd7:    w = '{act: ACT_SHIFT,   cond: C_NEXT,     target: PC_IDLE};
      4'd8:    w = '{act: ACT_NONE,    cond: C_EZERO,    target: PC_EMIT};
      4'd9:    w = '{act: ACT_MSQ_GO,  cond: C_NEXT,     target: PC_IDLE};
      4'd10:   w = '{act: ACT_WR_SQ,   cond: C_UNIT,     target: PC_BIT};
      4'd11:   w = '{act: ACT_EMIT,    cond: C_OUT,      target: PC_IDLE};
      default: w = '{act: ACT_NONE,    cond: C_JUMP,     target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/mme_mulmod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_mulmod: bit-serial modular multiply and reduce unit
// Scans operand b from the top bit, one bit per cycle. Multiply mode forms
// a*b mod m by double-and-add; reduce mode forms b mod m by shift-subtract.
// A zero modulus wraps at WIDTH bits.
// ----------------------------------------------------------------------------
module mme_mulmod #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             red_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] mod_i,
  output logic             done_o,
  output logic [WIDTH-1:0] res_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             red_q, red_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;

  logic             mod_nz;
  logic [WIDTH:0]   mod_ext;
  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   dbl_red;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   sum_red;
  logic             b_top;

  assign mod_nz  = |mod_i;
  assign mod_ext = {1'b0, mod_i};
  assign b_top   = b_q[WIDTH-1];

  always_comb begin
    dbl     = {r_q, (red_q & b_top)};
    dbl_red = (mod_nz && dbl >= mod_ext) ? dbl - mod_ext : dbl;
    sum     = {1'b0, dbl_red[WIDTH-1:0]} + {1'b0, a_q};
    sum_red = (mod_nz && sum >= mod_ext) ? sum - mod_ext : sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    red_d  = red_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      red_d  = red_i;
      cnt_d  = CNT_W'(WIDTH - 1);
      r_d    = '0;
      a_d    = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      r_d = (!red_q && b_top) ? sum_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
      b_d = {b_q[WIDTH-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q <= red_d;
    cnt_q <= cnt_d;
    r_q   <= r_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

@@ hw/rtl/mme_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_seq: microcode sequencer
// Step counter over the control store with waits and conditional jumps.
// ----------------------------------------------------------------------------
module mme_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mme_pkg::seq_stat_t stat_i,
  output mme_pkg::seq_ctrl_t ctrl_o
);

  import mme_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  logic [PC_W-1:0] pc_inc;
  uword_t          uw;
  logic            fire;

  assign uw     = ucode(pc_q);
  assign pc_inc = pc_q + 1'b1;

  always_comb begin
    fire = 1'b1;
    pc_d = pc_inc;
    case (uw.cond)
      C_NEXT: begin
        pc_d = pc_inc;
      end
      C_JUMP: begin
        pc_d = uw.target;
      end
      C_IN: begin
        fire = stat_i.in_fire;
        pc_d = fire ? pc_inc : pc_q;
      end
      C_UNIT: begin
        fire = stat_i.unit_done;
        pc_d = fire ? uw.target : pc_q;
      end
      C_OUT: begin
        fire = stat_i.out_free;
        pc_d = fire ? uw.target : pc_q;
      end
      C_EZERO: begin
        pc_d = stat_i.e_zero ? uw.target : pc_inc;
      end
      C_EBIT_CLR: begin
        pc_d = stat_i.e_bit0 ? pc_inc : uw.target;
      end
      default: begin
        fire = 1'b0;
        pc_d = PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.act  = uw.act;
  assign ctrl_o.fire = fire;

endmodule

@@ hw/rtl/modular_exponentiation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core: base^exponent mod modulus
// Right-to-left square-and-multiply run by a microcoded sequencer over one
// shared bit-serial modular multiplier.
//
// Usage: write exponent (index 0) and modulus (index 1) on the cfg channel
// while the core is idle; a zero modulus wraps at WIDTH bits. Each input beat
// (in_valid_i high, in_stall_o low) carries one base; one output beat carries
// power. in_stall_o is low only while the sequencer waits for a beat, so one
// item is in work at a time.
// A zero exponent skips the multiplier: after the load step the sequencer
// checks the exponent and goes straight to the output step.
// The result sits in an output register: the next item is accepted while it
// waits, and a stalled result holds until taken; the sequencer waits at its
// final step only if the older result is still pending.
// Reset clears the sequencer and the output valid and sets exponent 0 and
// modulus 1.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [WIDTH-1:0]              base_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [WIDTH-1:0]              power_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WIDTH-1:0]              cfg_data_i
);

  import mme_pkg::*;

  localparam logic [WIDTH-1:0] One = WIDTH'(1);

  logic [WIDTH-1:0] exponent_q, exponent_d;
  logic [WIDTH-1:0] modulus_q, modulus_d;
  logic [WIDTH-1:0] e_q, e_d;
  logic [WIDTH-1:0] sq_q, sq_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] power_q, power_d;
  logic             out_valid_q, out_valid_d;

  seq_stat_t        stat;
  seq_ctrl_t        ctrl;
  logic             in_fire;
  logic             act_fire;
  logic             unit_start;
  logic             unit_red;
  logic [WIDTH-1:0] unit_a;
  logic             unit_done;
  logic [WIDTH-1:0] unit_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (ctrl.act != ACT_LOAD);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign act_fire    = ctrl.fire;

  assign stat.in_fire   = in_fire;
  assign stat.unit_done = unit_done;
  assign stat.out_free  = !out_valid_q || !out_stall_i;
  assign stat.e_zero    = (e_q == '0);
  assign stat.e_bit0    = e_q[0];

  mme_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign unit_start = (ctrl.act == ACT_RED_GO) || (ctrl.act == ACT_MACC_GO)
                   || (ctrl.act == ACT_MSQ_GO);
  assign unit_red   = (ctrl.act == ACT_RED_GO);
  assign unit_a     = (ctrl.act == ACT_MACC_GO) ? acc_q : sq_q;

  mme_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .red_i   (unit_red),
    .a_i     (unit_a),
    .b_i     (sq_q),
    .mod_i   (modulus_q),
    .done_o  (unit_done),
    .res_o   (unit_res)
  );

  always_comb begin
    exponent_d = exponent_q;
    modulus_d  = modulus_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_EXPONENT: exponent_d = cfg_data_i;
        CFG_MODULUS:  modulus_d  = cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_comb begin
    e_d   = e_q;
    sq_d  = sq_q;
    acc_d = acc_q;
    if (act_fire) begin
      case (ctrl.act)
        ACT_LOAD: begin
          e_d   = exponent_q;
          sq_d  = base_i;
          acc_d = (modulus_q == One && exponent_q != '0) ? '0 : One;
        end
        ACT_WR_SQ:  sq_d  = unit_res;
        ACT_WR_ACC: acc_d = unit_res;
        ACT_SHIFT:  e_d   = {1'b0, e_q[WIDTH-1:1]};
        default:    ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    power_d     = power_q;
    if (act_fire && ctrl.act == ACT_EMIT) begin
      out_valid_d = 1'b1;
      power_d     = acc_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q  <= '0;
      modulus_q   <= One;
      out_valid_q <= 1'b0;
    end else begin
      exponent_q  <= exponent_d;
      modulus_q   <= modulus_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q     <= e_d;
    sq_q    <= sq_d;
    acc_q   <= acc_d;
    power_q <= power_d;
  end

  assign out_valid_o = out_valid_q;
  assign power_o     = power_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (ctrl.act == ACT_WR_SQ || ctrl.act == ACT_WR_ACC))
    else $error("multiplier finished outside a write-back step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input taken again right after a beat");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_fire && ctrl.act == ACT_EMIT) |=> out_valid_o)
    else $error("result emitted without output valid");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_start |=> !unit_done)
    else $error("multiplier reported done right after launch");

endmodule
